@@ rtl/core/secd_pkg.sv @@
// ----------------------------------------------------------------------------
// secd_pkg: shared constants for the serial EEPROM command decoder
// Status, action and register codes, stream lengths and memory geometry.
// ----------------------------------------------------------------------------
package secd_pkg;

   // word memory geometry
   localparam int WORD_DEPTH = 1024;
   localparam int WORD_BITS  = 64;
   localparam int ADDR_BITS  = $clog2(WORD_DEPTH);

   // decoded address width at the port
   localparam int WADDR_W = 14;

   // newest bits of the stream that are kept: header-free tail of a 14-bit write
   localparam int SHIFT_BITS = WORD_BITS + 15;

   // stream lengths
   localparam logic [6:0] STORE_DEPTH = 7'd81;
   localparam logic [6:0] COUNT_SAT   = 7'd82;
   localparam logic [6:0] MIN_BITS    = 7'd9;
   localparam logic [6:0] READ_LEN6   = 7'd9;
   localparam logic [6:0] READ_LEN14  = 7'd17;
   localparam logic [6:0] WRITE_LEN6  = 7'd73;
   localparam logic [6:0] WRITE_LEN14 = 7'd81;

   // input actions
   localparam logic [1:0] ACT_BIT  = 2'd0;
   localparam logic [1:0] ACT_END  = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   // width codes
   localparam logic [1:0] WID_AUTO = 2'd0;
   localparam logic [1:0] WID_6    = 2'd1;
   localparam logic [1:0] WID_14   = 2'd2;

   // result status
   localparam logic [2:0] STAT_READ     = 3'd0;
   localparam logic [2:0] STAT_WRITE    = 3'd1;
   localparam logic [2:0] STAT_DISABLED = 3'd2;
   localparam logic [2:0] STAT_BUSY     = 3'd3;
   localparam logic [2:0] STAT_SHORT    = 3'd4;
   localparam logic [2:0] STAT_BADSTART = 3'd5;
   localparam logic [2:0] STAT_BADLEN   = 3'd6;

   // configuration register indexes
   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_BUSY   = 2'd2;

   localparam logic [19:0] BUSY_RESET = 20'd65536;

endpackage

@@ rtl/core/secd_ram.sv @@
// ----------------------------------------------------------------------------
// secd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module secd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/serial_eeprom_command_decoder.sv @@
// ----------------------------------------------------------------------------
// serial_eeprom_command_decoder: bit-serial EEPROM command decoder
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  action, bit_value, tick_cycles
//   rsp_     out        rsp_valid/rsp_stall  status, read_data, word_address,
//                                            ready_flag
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A command bit, a tick or an unused action is taken without leaving idle. An
// end-of-stream word passes through accept, decode and result steps and waits
// in the result step while rsp_stall is high; the single read port of the word
// memory sets the decode step. After reset the 1024-word memory is cleared in
// a pass with req_stall high. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module serial_eeprom_command_decoder
   import secd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_action,
   input  logic                 req_bit_value,
   input  logic [15:0]          req_tick_cycles,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [WORD_BITS-1:0] rsp_read_data,
   output logic [WADDR_W-1:0]   rsp_word_address,
   output logic                 rsp_ready_flag,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [19:0]          csr_wdata
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_EMIT  = 2'd2;

   // control state
   logic [1:0]            state_ff, state_in;
   logic                  clr_ff, clr_in;
   logic [ADDR_BITS-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                  enable_ff, enable_in;
   logic [1:0]            width_ff, width_in;
   logic [19:0]           busy_cfg_ff, busy_cfg_in;
   logic [6:0]            count_ff, count_in;
   logic [1:0]            det_ff, det_in;
   logic                  ready_ff, ready_in;
   logic [20:0]           cd_ff, cd_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   logic                  bit0_ff, bit0_in;
   logic                  bit1_ff, bit1_in;
   logic [SHIFT_BITS-1:0] shift_ff, shift_in;
   logic [2:0]            pend_status_ff, pend_status_in;
   logic [WADDR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic                  pend_ones_ff, pend_ones_in;
   logic                  pend_ram_ff, pend_ram_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [WORD_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [WADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic                  rsp_ready_ff, rsp_ready_in;

   // decode
   logic                  req_take;
   logic                  slot_free;
   logic                  is_read;
   logic                  auto_mode;
   logic                  len6, len14;
   logic [1:0]            det_next;
   logic [1:0]            act_code;
   logic                  len_ok;
   logic [WADDR_W-1:0]    dec_addr;
   logic                  out_range;

   // memory port
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;
   logic                  ram_re;
   logic [WORD_BITS-1:0]  ram_rdata;

   assign req_stall = clr_ff | (state_ff != S_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign csr_ready = 1'b1;

   assign is_read   = bit1_ff;
   assign auto_mode = (width_ff != WID_6) && (width_ff != WID_14);
   assign len6      = is_read ? (count_ff == READ_LEN6)  : (count_ff == WRITE_LEN6);
   assign len14     = is_read ? (count_ff == READ_LEN14) : (count_ff == WRITE_LEN14);

   always_comb begin
      det_next = det_ff;
      if (auto_mode && det_ff == WID_AUTO) begin
         if (len6) begin
            det_next = WID_6;
         end else if (len14) begin
            det_next = WID_14;
         end
      end
   end

   assign act_code = auto_mode ? det_next : width_ff;
   assign len_ok   = ((act_code == WID_6) && len6) || ((act_code == WID_14) && len14);

   // address sits just before the trailing bit (read) or the data word (write)
   always_comb begin
      if (is_read) begin
         dec_addr = (act_code == WID_6) ? {8'd0, shift_ff[6:1]} : shift_ff[14:1];
      end else begin
         dec_addr = (act_code == WID_6) ? {8'd0, shift_ff[WORD_BITS+6:WORD_BITS+1]}
                                        : shift_ff[WORD_BITS+14:WORD_BITS+1];
      end
   end

   assign out_range = dec_addr >= WADDR_W'(WORD_DEPTH);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      clr_cnt_in     = clr_cnt_ff;
      enable_in      = enable_ff;
      width_in       = width_ff;
      busy_cfg_in    = busy_cfg_ff;
      count_in       = count_ff;
      det_in         = det_ff;
      ready_in       = ready_ff;
      cd_in          = cd_ff;
      rsp_valid_in   = rsp_valid_ff;
      bit0_in        = bit0_ff;
      bit1_in        = bit1_ff;
      shift_in       = shift_ff;
      pend_status_in = pend_status_ff;
      pend_addr_in   = pend_addr_ff;
      pend_ones_in   = pend_ones_ff;
      pend_ram_in    = pend_ram_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_ready_in   = rsp_ready_ff;
      ram_we         = 1'b0;
      ram_waddr      = dec_addr[ADDR_BITS-1:0];
      ram_wdata      = shift_ff[WORD_BITS:1];
      ram_re         = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE: enable_in   = csr_wdata[0];
            CSR_WIDTH:  width_in    = csr_wdata[1:0];
            CSR_BUSY:   busy_cfg_in = csr_wdata;
            default: ;
         endcase
      end

      // sweep the word memory to zero after reset
      if (clr_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
         if (clr_cnt_ff == ADDR_BITS'(WORD_DEPTH - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_action)
                  ACT_BIT: begin
                     if (count_ff < STORE_DEPTH) begin
                        if (count_ff == 7'd0) begin
                           bit0_in = req_bit_value;
                        end
                        if (count_ff == 7'd1) begin
                           bit1_in = req_bit_value;
                        end
                        shift_in = {shift_ff[SHIFT_BITS-2:0], req_bit_value};
                        count_in = count_ff + 7'd1;
                     end else begin
                        count_in = COUNT_SAT;
                     end
                  end
                  ACT_END: begin
                     state_in = S_CHECK;
                  end
                  ACT_TICK: begin
                     if (cd_ff != 21'd0) begin
                        if ({5'd0, req_tick_cycles} >= cd_ff) begin
                           cd_in    = 21'd0;
                           ready_in = 1'b1;
                        end else begin
                           cd_in = cd_ff - {5'd0, req_tick_cycles};
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            pend_addr_in = '0;
            pend_ones_in = 1'b0;
            pend_ram_in  = 1'b0;
            count_in     = 7'd0;
            state_in     = S_EMIT;
            if (!enable_ff) begin
               pend_status_in = STAT_DISABLED;
               count_in       = count_ff;
            end else if (!ready_ff) begin
               pend_status_in = STAT_BUSY;
            end else if (count_ff < MIN_BITS) begin
               pend_status_in = STAT_SHORT;
            end else if (!bit0_ff) begin
               pend_status_in = STAT_BADSTART;
            end else begin
               det_in = det_next;
               if (!len_ok) begin
                  pend_status_in = STAT_BADLEN;
               end else if (is_read) begin
                  pend_status_in = STAT_READ;
                  pend_addr_in   = dec_addr;
                  pend_ones_in   = out_range;
                  pend_ram_in    = ~out_range;
                  ram_re         = ~out_range;
               end else begin
                  pend_status_in = STAT_WRITE;
                  pend_addr_in   = dec_addr;
                  if (!out_range) begin
                     ram_we   = 1'b1;
                     ready_in = 1'b0;
                     cd_in    = (busy_cfg_ff == 20'd0) ? 21'd1 : {1'b0, busy_cfg_ff};
                  end
               end
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_addr_in   = pend_addr_ff;
               rsp_ready_in  = ready_ff;
               rsp_data_in   = pend_ram_ff ? ram_rdata : {WORD_BITS{pend_ones_ff}};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         enable_ff    <= 1'b1;
         width_ff     <= WID_AUTO;
         busy_cfg_ff  <= BUSY_RESET;
         count_ff     <= 7'd0;
         det_ff       <= WID_AUTO;
         ready_ff     <= 1'b1;
         cd_ff        <= 21'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_cnt_ff   <= clr_cnt_in;
         enable_ff    <= enable_in;
         width_ff     <= width_in;
         busy_cfg_ff  <= busy_cfg_in;
         count_ff     <= count_in;
         det_ff       <= det_in;
         ready_ff     <= ready_in;
         cd_ff        <= cd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit0_ff        <= bit0_in;
      bit1_ff        <= bit1_in;
      shift_ff       <= shift_in;
      pend_status_ff <= pend_status_in;
      pend_addr_ff   <= pend_addr_in;
      pend_ones_ff   <= pend_ones_in;
      pend_ram_ff    <= pend_ram_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_ready_ff   <= rsp_ready_in;
   end

   secd_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (dec_addr[ADDR_BITS-1:0]),
      .rd_data (ram_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_word_address = rsp_addr_ff;
   assign rsp_ready_flag   = rsp_ready_ff;

endmodule
